FILE: hdl/banked_register_file_macros.svh
// Assertion macros shared by the banked register file RTL.
`ifndef BANKED_REGISTER_FILE_MACROS_SVH
`define BANKED_REGISTER_FILE_MACROS_SVH

// Check a property at every rising edge of clk_i outside reset.
`define BRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence on the next edge.
`define BRF_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/brf_pkg.sv
// Package with request/response types and codes of the banked register file.
package brf_pkg;

  // Action codes
  localparam logic [3:0] ACT_RD8     = 4'd0;
  localparam logic [3:0] ACT_RD16    = 4'd1;
  localparam logic [3:0] ACT_RD32    = 4'd2;
  localparam logic [3:0] ACT_WR8     = 4'd3;
  localparam logic [3:0] ACT_WR16    = 4'd4;
  localparam logic [3:0] ACT_WR32    = 4'd5;
  localparam logic [3:0] ACT_ADD     = 4'd6;
  localparam logic [3:0] ACT_SUB     = 4'd7;
  localparam logic [3:0] ACT_CPSR_RD = 4'd8;
  localparam logic [3:0] ACT_CPSR_WR = 4'd9;
  localparam logic [3:0] ACT_SPSR_RD = 4'd10;
  localparam logic [3:0] ACT_SPSR_WR = 4'd11;
  localparam logic [3:0] ACT_PREF_RD = 4'd12;
  localparam logic [3:0] ACT_PREF_WR = 4'd13;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_NO_SPSR  = 2'd2;

  // Processor modes
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Register file geometry
  localparam int unsigned SHARED_COUNT = 8;
  localparam int unsigned GPR_COUNT    = 31;
  localparam int unsigned SPSR_COUNT   = 5;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] value;
  } brf_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } brf_rsp_t;

  // Resolved banking for the current mode and index
  typedef struct packed {
    logic       mode_ok;   // mode is one of the seven defined modes
    logic       user_bank; // usr or sys: no saved status word
    logic [2:0] spsr_idx;  // saved status slot: fiq, svc, abt, irq, und
    logic [4:0] phys;      // physical general register
  } brf_map_t;

endpackage

FILE: hdl/brf_bank_map.sv
// Mode decode and logical-to-physical register mapping.
module brf_bank_map import brf_pkg::*; (
  input  logic [4:0] mode_i,
  input  logic [3:0] reg_index_i,
  output brf_map_t   map_o
);

  logic [2:0] bank;

  always_comb begin
    map_o.mode_ok   = 1'b1;
    map_o.user_bank = 1'b0;
    bank            = 3'd0;
    case (mode_i)
      MODE_USR: begin
        bank = 3'd0;
        map_o.user_bank = 1'b1;
      end
      MODE_SYS: begin
        bank = 3'd0;
        map_o.user_bank = 1'b1;
      end
      MODE_FIQ: bank = 3'd1;
      MODE_SVC: bank = 3'd2;
      MODE_ABT: bank = 3'd3;
      MODE_IRQ: bank = 3'd4;
      MODE_UND: bank = 3'd5;
      default: begin
        bank = 3'd0;
        map_o.mode_ok = 1'b0;
      end
    endcase

    map_o.spsr_idx = bank - 3'd1;

    // r0..r7 and r15 are shared, r8..r12 have a fiq bank, r13/r14 per mode
    if (reg_index_i < 4'(SHARED_COUNT)) begin
      map_o.phys = {1'b0, reg_index_i};
    end else if (reg_index_i == 4'd15) begin
      map_o.phys = 5'd30;
    end else if (reg_index_i <= 4'd12) begin
      map_o.phys = (bank == 3'd1) ? ({1'b0, reg_index_i} + 5'd5) : {1'b0, reg_index_i};
    end else if (reg_index_i == 4'd13) begin
      map_o.phys = 5'd18 + {2'b00, bank};
    end else begin
      map_o.phys = 5'd24 + {2'b00, bank};
    end
  end

endmodule

FILE: hdl/banked_register_file.sv
// Top level of the banked register file.
// Banked register file of a 32-bit core. One request is taken at every clock
// edge where start_i is high; busy_o is always low. An accepted request is
// latched in the input register, resolved and applied to the register state
// during the following cycle, and its result is captured in the result
// register and appears on rsp_o with valid_o high for exactly one cycle.
// Throughput is one request per cycle, set by the input register and the
// result register around the single decode-and-update pass. The receiver
// cannot stall: a result not taken in its strobe cycle is gone.
// Back-to-back requests see each other's updates, because state is written at
// the same edge that captures the result. The current mode is the low five
// bits of the status word; after reset it is zero, so register and saved
// status accesses report an invalid mode until the status word is written.
module banked_register_file import brf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  brf_req_t req_i,
  output logic     valid_o,
  output brf_rsp_t rsp_o
);

  // Input stage
  brf_req_t req_q;
  logic     req_valid_q;

  // Architectural state
  logic [31:0] gpr_q  [GPR_COUNT];
  logic [31:0] spsr_q [SPSR_COUNT];
  logic [31:0] cpsr_q, cpsr_d;
  logic [31:0] pref_q, pref_d;

  // Result stage
  brf_rsp_t rsp_q, rsp_d;
  logic     rsp_valid_q;

  // Update pass
  brf_map_t    map;
  logic [31:0] cur_reg;
  logic        gpr_we;
  logic [31:0] gpr_wdata;
  logic        spsr_we;

  // Never hold requests off: every access finishes in one pass
  assign busy_o = 1'b0;

  brf_bank_map u_bank_map (
    .mode_i      (cpsr_q[4:0]),
    .reg_index_i (req_q.reg_index),
    .map_o       (map)
  );

  assign cur_reg = gpr_q[map.phys];

  always_comb begin
    rsp_d     = '{read_data: 32'd0, status: ST_OK};
    gpr_we    = 1'b0;
    gpr_wdata = cur_reg;
    spsr_we   = 1'b0;
    cpsr_d    = cpsr_q;
    pref_d    = pref_q;

    if (req_valid_q) begin
      if (req_q.action <= ACT_SUB) begin
        // Register access: refuse and leave state alone in an invalid mode
        if (!map.mode_ok) begin
          rsp_d.status = ST_BAD_MODE;
        end else begin
          case (req_q.action)
            ACT_RD8:  rsp_d.read_data = {24'd0, cur_reg[7:0]};
            ACT_RD16: rsp_d.read_data = {16'd0, cur_reg[15:0]};
            ACT_RD32: rsp_d.read_data = cur_reg;
            ACT_WR8: begin
              gpr_we    = 1'b1;
              gpr_wdata = {cur_reg[31:8], req_q.value[7:0]};
            end
            ACT_WR16: begin
              gpr_we    = 1'b1;
              gpr_wdata = {cur_reg[31:16], req_q.value[15:0]};
            end
            ACT_WR32: begin
              gpr_we    = 1'b1;
              gpr_wdata = req_q.value;
            end
            ACT_ADD: begin
              gpr_we    = 1'b1;
              gpr_wdata = cur_reg + req_q.value;
            end
            default: begin
              gpr_we    = 1'b1;
              gpr_wdata = cur_reg - req_q.value;
            end
          endcase
          if (gpr_we) begin
            rsp_d.read_data = gpr_wdata;
          end
        end
      end else begin
        case (req_q.action)
          ACT_CPSR_RD: rsp_d.read_data = cpsr_q;
          ACT_CPSR_WR: begin
            cpsr_d          = req_q.value;
            rsp_d.read_data = req_q.value;
          end
          ACT_SPSR_RD, ACT_SPSR_WR: begin
            if (!map.mode_ok) begin
              rsp_d.status = ST_BAD_MODE;
            end else if (map.user_bank) begin
              rsp_d.status = ST_NO_SPSR;
            end else if (req_q.action == ACT_SPSR_WR) begin
              spsr_we         = 1'b1;
              rsp_d.read_data = req_q.value;
            end else begin
              rsp_d.read_data = spsr_q[map.spsr_idx];
            end
          end
          ACT_PREF_RD: rsp_d.read_data = pref_q;
          ACT_PREF_WR: begin
            pref_d          = req_q.value;
            rsp_d.read_data = req_q.value;
          end
          default: ; // unused codes: drop the request, report ok and zero
        endcase
      end
    end
  end

  // Latch the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  // Apply the update and capture the result at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GPR_COUNT; i++) begin
        gpr_q[i] <= 32'd0;
      end
      for (int i = 0; i < SPSR_COUNT; i++) begin
        spsr_q[i] <= 32'd0;
      end
      cpsr_q      <= 32'd0;
      pref_q      <= 32'd0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (gpr_we) begin
        gpr_q[map.phys] <= gpr_wdata;
      end
      if (spsr_we) begin
        spsr_q[map.spsr_idx] <= req_q.value;
      end
      cpsr_q      <= cpsr_d;
      pref_q      <= pref_d;
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = rsp_valid_q;
  assign rsp_o   = rsp_q;

`include "banked_register_file_macros.svh"

  // A refused access never returns data
  `BRF_ASSERT(a_err_zero, !(valid_o && rsp_o.status != ST_OK) || rsp_o.read_data == 32'd0, "error result carries data")
  // Every latched request yields exactly one strobe on the next edge
  `BRF_ASSERT_NEXT(a_strobe_follows, req_valid_q, valid_o, "missing result strobe")
  `BRF_ASSERT_NEXT(a_no_spurious, !req_valid_q, !valid_o, "result strobe without request")
  // A status word write is visible to the next pass
  `BRF_ASSERT_NEXT(a_cpsr_wr, req_valid_q && req_q.action == ACT_CPSR_WR, cpsr_q == $past(req_q.value), "status word write lost")

endmodule
